### hw/rtl/wavelet53_line_analysis_defines.svh
// Assertion macros shared by the wavelet line analysis RTL.
// Depends on nothing; files that assert take it by include and supply clk and rst_n.
`ifndef WAVELET53_LINE_ANALYSIS_DEFINES_SVH
`define WAVELET53_LINE_ANALYSIS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define W53_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define W53_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/w53_pkg.sv
// Shared types and constants of the 5/3 wavelet line analysis block.
// No dependencies; used by w53_kernel and wavelet53_line_analysis.
package w53_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_Q_W   = 11;
    localparam int LP_W      = 20;
    localparam int HP_W      = 18;

    // Configuration register indexes.
    localparam logic CFG_IDX_HIGH_PASS_MODE = 1'b0;
    localparam logic CFG_IDX_QUARTER_WIDTH  = 1'b1;

    localparam logic [CFG_Q_W-1:0] QUARTER_WIDTH_RESET = 11'd128;
    localparam logic [CFG_Q_W-1:0] QUARTER_WIDTH_MIN   = 11'd2;

    // Rounding bias for the division by sixteen of the low-pass sum.
    localparam logic [LP_W-1:0] LP_ROUND_BIAS = 20'd8;

    // What a sample produces at its position in the line.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LP_EDGE   = 3'd1,
        OP_LP_MID    = 3'd2,
        OP_LP_LAST   = 3'd3,
        OP_HP_FIRST  = 3'd4,
        OP_HP_SECOND = 3'd5,
        OP_HP_LAST   = 3'd6
    } w53_op_kind_t;

    // Operands of one coefficient, chosen from the sample window.
    // Low-pass: 6a + 2(b+c) - (d+e). High-pass: (a - half(b+c))/2, or (c-b+1)/2 at line end.
    typedef struct packed {
        w53_op_kind_t                kind;
        logic signed [SAMPLE_W-1:0]  a;
        logic signed [SAMPLE_W-1:0]  b;
        logic signed [SAMPLE_W-1:0]  c;
        logic signed [SAMPLE_W-1:0]  d;
        logic signed [SAMPLE_W-1:0]  e;
        logic                        odd_fix;
        logic                        line_done;
    } w53_op_t;

endpackage

### hw/rtl/wavelet53_line_analysis.sv
// Le Gall 5/3 wavelet line analysis: stream of samples in, one band of coefficients out.
// Depends on w53_pkg, w53_kernel and wavelet53_line_analysis_defines.svh.
//
// The block takes one sample per cycle and gives one coefficient for every second
// sample of a line of 4*quarter_width samples (the band chosen by high_pass_mode),
// with tlast on the last coefficient of the line. A sample passes through two registers in the
// block: first the operand register, after which the filter arithmetic fills the
// output register. The two registers form a pipeline, so a new sample is taken every
// cycle while the output side keeps up; a stalled output holds one result and one
// operand set before the input stops. Configuration writes are always taken and
// should be made only while no line is in progress.
`include "wavelet53_line_analysis_defines.svh"

module wavelet53_line_analysis
    import w53_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample
    // Coefficient output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [15:0] coefficient
    output logic                 m_axis_tlast,   // line_done
    // Register writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_Q_W-1:0]   cfg_data
);

    localparam int LW      = $clog2(MAX_LINE_WIDTH) + 1;
    localparam int QX      = (LW > CFG_Q_W) ? LW : CFG_Q_W;
    localparam int Q_MAX   = MAX_LINE_WIDTH / 4;
    localparam logic [QX-1:0] Q_MAX_V = QX'(Q_MAX);

    logic                        mode_reg;
    logic [CFG_Q_W-1:0]          quarter_reg;
    logic signed [SAMPLE_W-1:0]  win_reg [4];
    logic [LW-1:0]               pos_reg;
    logic                        odd_reg;
    logic                        s1_valid_reg;
    w53_op_t                     s1_op_reg;
    logic                        out_valid_reg;
    logic [COEF_W-1:0]           out_data_reg;
    logic                        out_last_reg;

    logic                        in_accept;
    logic                        out_free;
    logic [QX-1:0]               q_ext;
    logic [QX-1:0]               q_clamp;
    logic [LW-1:0]               last_idx;
    logic [LW-1:0]               p;
    logic                        last;
    logic signed [SAMPLE_W-1:0]  cur;
    w53_op_t                     op_next;
    logic                        odd_next;
    logic [LW-1:0]               pos_next;
    logic signed [COEF_W-1:0]    coef;

    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign cur           = signed'(s_axis_tdata);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            quarter_reg <= QUARTER_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_HIGH_PASS_MODE: mode_reg    <= cfg_data[0];
                CFG_IDX_QUARTER_WIDTH:  quarter_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Line length and position of the current sample, clamped to the last index.
    always_comb
    begin
        q_ext = QX'(quarter_reg);
        if (q_ext < QX'(QUARTER_WIDTH_MIN))
            q_clamp = QX'(QUARTER_WIDTH_MIN);
        else if (q_ext > Q_MAX_V)
            q_clamp = Q_MAX_V;
        else
            q_clamp = q_ext;
        last_idx = LW'({q_clamp, 2'b00}) - LW'(1);
        p        = (pos_reg > last_idx) ? last_idx : pos_reg;
        last     = (p == last_idx);
        pos_next = last ? '0 : p + LW'(1);
    end

    // Choose the coefficient kind and its operands from the sample window.
    always_comb
    begin
        op_next           = '0;
        op_next.kind      = OP_NONE;
        op_next.line_done = last;
        op_next.odd_fix   = 1'b0;
        if (!mode_reg)
        begin
            if (last)
            begin
                op_next.kind = OP_LP_LAST;
                op_next.a    = win_reg[0];
                op_next.b    = win_reg[1];
                op_next.c    = cur;
                op_next.d    = win_reg[2];
                op_next.e    = win_reg[0];
            end
            else if (p == LW'(2))
            begin
                // Left edge: mirrored neighbours fold into the centre taps.
                op_next.kind = OP_LP_EDGE;
                op_next.a    = win_reg[1];
                op_next.b    = win_reg[0];
                op_next.c    = win_reg[0];
                op_next.d    = cur;
                op_next.e    = cur;
            end
            else if (p >= LW'(4) && !p[0])
            begin
                op_next.kind = OP_LP_MID;
                op_next.a    = win_reg[1];
                op_next.b    = win_reg[2];
                op_next.c    = win_reg[0];
                op_next.d    = win_reg[3];
                op_next.e    = cur;
            end
        end
        else
        begin
            if (last)
            begin
                op_next.kind = OP_HP_LAST;
                op_next.b    = win_reg[0];
                op_next.c    = cur;
            end
            else if (p[1:0] == 2'd2)
            begin
                op_next.kind = OP_HP_FIRST;
                op_next.a    = win_reg[0];
                op_next.b    = win_reg[1];
                op_next.c    = cur;
            end
            else if (p[1:0] == 2'd0 && p >= LW'(4))
            begin
                op_next.kind    = OP_HP_SECOND;
                op_next.a       = win_reg[0];
                op_next.b       = win_reg[1];
                op_next.c       = cur;
                op_next.odd_fix = odd_reg;
            end
        end
    end

    // Parity of the first pair sum, kept in both modes.
    always_comb
    begin
        odd_next = odd_reg;
        if (last)
            odd_next = 1'b0;
        else if (p[1:0] == 2'd2)
            odd_next = win_reg[1][0] ^ cur[0];
        else if (p[1:0] == 2'd0)
            odd_next = 1'b0;
    end

    // Line state: position and parity flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            odd_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            pos_reg <= pos_next;
            odd_reg <= odd_next;
        end
    end

    // Sample window, reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                win_reg[i] <= '0;
        end
        else if (in_accept)
        begin
            win_reg[3] <= win_reg[2];
            win_reg[2] <= win_reg[1];
            win_reg[1] <= win_reg[0];
            win_reg[0] <= cur;
        end
    end

    // Operand stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= in_accept && (op_next.kind != OP_NONE);
    end

    // Operand stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_op_reg <= op_next;
    end

    w53_kernel u_kernel
    (
        .op          (s1_op_reg),
        .coefficient (coef)
    );

    // Output stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= coef;
            out_last_reg <= s1_op_reg.line_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // The last sample of a line sends the position back to the start.
    `W53_ASSERT_NEXT(a_line_wrap, in_accept && last, pos_reg == '0, "position not cleared at line end")
    // At the start of a line no pair parity is pending.
    `W53_ASSERT_NOW(a_odd_clear, pos_reg == '0, !odd_reg, "pair parity set at line start")
    // A pending operand set moves on when the output register is free.
    `W53_ASSERT_NEXT(a_stage_move, s1_valid_reg && !out_valid_reg, out_valid_reg, "operand stage stuck")

endmodule

### hw/rtl/w53_kernel.sv
// Filter arithmetic of the 5/3 wavelet: one coefficient from registered operands.
// Depends on w53_pkg.
module w53_kernel
    import w53_pkg::*;
(
    input  w53_op_t                   op,
    output logic signed [COEF_W-1:0]  coefficient
);

    logic signed [LP_W-1:0]     lp_sum;
    logic        [LP_W-1:0]     lp_mag;
    logic        [LP_W-1:0]     lp_rnd;
    logic signed [LP_W-1:0]     lp_val;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   pair_half;
    logic signed [SAMPLE_W:0]   fix_s;
    logic signed [HP_W-1:0]     hp_diff;
    logic signed [HP_W-1:0]     hp_pos;
    logic signed [HP_W-1:0]     hp_val;
    logic signed [HP_W-1:0]     end_diff;
    logic signed [HP_W-1:0]     end_val;
    logic signed [LP_W-1:0]     value;

    // Low-pass sum, then divide by sixteen rounding halves away from zero.
    always_comb
    begin
        lp_sum = (LP_W'(op.a) <<< 2) + (LP_W'(op.a) <<< 1)
               + ((LP_W'(op.b) + LP_W'(op.c)) <<< 1)
               - (LP_W'(op.d) + LP_W'(op.e));
        lp_mag = lp_sum[LP_W-1] ? LP_W'(-lp_sum) : LP_W'(lp_sum);
        lp_rnd = (lp_mag + LP_ROUND_BIAS) >> 4;
        lp_val = lp_sum[LP_W-1] ? -signed'(lp_rnd) : signed'(lp_rnd);
    end

    // High-pass: predict from the pair average, then halve rounding positives up.
    always_comb
    begin
        pair_sum  = (SAMPLE_W+1)'(op.b) + (SAMPLE_W+1)'(op.c);
        pair_half = pair_sum >>> 1;
        fix_s     = signed'({{SAMPLE_W{1'b0}}, op.odd_fix & pair_sum[0]});
        hp_diff   = HP_W'(op.a) - HP_W'(pair_half + fix_s);
        hp_pos    = signed'({{(HP_W-1){1'b0}}, (hp_diff > 0)});
        hp_val    = (hp_diff + hp_pos) >>> 1;
        end_diff  = HP_W'(op.c) - HP_W'(op.b) + HP_W'(1);
        end_val   = end_diff >>> 1;
    end

    // Band selection and saturation to the coefficient width.
    always_comb
    begin
        case (op.kind) inside
            OP_LP_EDGE, OP_LP_MID, OP_LP_LAST: value = lp_val;
            OP_HP_FIRST, OP_HP_SECOND:         value = LP_W'(hp_val);
            OP_HP_LAST:                        value = LP_W'(end_val);
            default:                           value = '0;
        endcase
        if (value > LP_W'(32767))
            coefficient = 16'sh7FFF;
        else if (value < -LP_W'(32768))
            coefficient = -16'sh8000;
        else
            coefficient = value[COEF_W-1:0];
    end

endmodule

### tb/wavelet53_line_analysis_checker.sv
// Checker for the 5/3 wavelet line analysis block: watches the sample, coefficient and
// register channels, predicts each coefficient and compares it with what the block gives.
// Depends on w53_pkg for widths and register indexes.
module wavelet53_line_analysis_checker
    import w53_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [15:0]          m_axis_tdata,   // [15:0] coefficient
    input  logic                 m_axis_tlast,   // line_done
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_Q_W-1:0]   cfg_data,
    output int                   mismatch_count,
    output int                   coefs_outstanding
);

    localparam int MAX_QUARTER = MAX_LINE_WIDTH / 4;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              line_done;
    } band_coef_t;

    // Shadow copy of the registers and of the line state.
    logic                       band_is_high;
    logic [CFG_Q_W-1:0]         quarter_width;
    logic signed [SAMPLE_W-1:0] recent_samples [4];
    logic [11:0]                line_position;
    logic                       first_sum_odd;

    band_coef_t expected_coefs [$];

    function automatic int half_floor(input int a);
        return a >>> 1;
    endfunction

    // Division by sixteen, to nearest with halves away from zero.
    function automatic int round_sixteenth(input int r);
        if (r >= 0)
            return (r + 8) / 16;
        return -((-r + 8) / 16);
    endfunction

    function automatic int halve_round_up(input int r);
        if (r > 0)
            return (r + 1) / 2;
        return r >>> 1;
    endfunction

    function automatic logic [COEF_W-1:0] clip_coef(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COEF_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("checker: %s (t=%0t)", msg, $time);
        mismatch_count++;
    endtask

    // Advances the line by one sample and works out the coefficient it releases, if any.
    task automatic filter_sample(input logic [SAMPLE_W-1:0] raw, output bit produced,
                                 output band_coef_t res);
        int  q;
        int  len;
        int  p;
        int  cur;
        int  w0;
        int  w1;
        int  w2;
        int  w3;
        int  v;
        int  pair_sum;
        bit  last;
        q = quarter_width;
        cur = $signed(raw);
        w0 = recent_samples[0];
        w1 = recent_samples[1];
        w2 = recent_samples[2];
        w3 = recent_samples[3];
        v = 0;
        produced = 1'b0;
        if (q < 2)
            q = 2;
        if (q > MAX_QUARTER)
            q = MAX_QUARTER;
        len = 4 * q;
        p = line_position;
        // A line shortened under a running position ends on this sample.
        if (p > len - 1)
            p = len - 1;
        last = (p == len - 1);

        if (!band_is_high)
        begin
            if (last)
            begin
                v = round_sixteenth(6 * w0 + 2 * (w1 + cur) - (w2 + w0));
                produced = 1'b1;
            end
            else if (p == 2)
            begin
                // Left end mirrored onto the first coefficient.
                v = round_sixteenth(6 * w1 + 4 * w0 - 2 * cur);
                produced = 1'b1;
            end
            else if (p >= 4 && p[0] == 1'b0)
            begin
                v = round_sixteenth(6 * w1 + 2 * (w2 + w0) - (w3 + cur));
                produced = 1'b1;
            end
        end
        else
        begin
            if (last)
            begin
                v = half_floor(cur - w0 + 1);
                produced = 1'b1;
            end
            else if (p[1:0] == 2'd2)
            begin
                v = halve_round_up(w0 - half_floor(w1 + cur));
                produced = 1'b1;
            end
            else if (p[1:0] == 2'd0 && p >= 4)
            begin
                // Second of the pair rounds up only when both pair sums were odd.
                pair_sum = w1 + cur;
                if (pair_sum[0] && first_sum_odd)
                    pair_sum++;
                v = halve_round_up(w0 - half_floor(pair_sum));
                produced = 1'b1;
            end
        end

        // The odd-sum flag follows the line in both bands.
        if (!last && p[1:0] == 2'd2)
        begin
            pair_sum = w1 + cur;
            first_sum_odd = pair_sum[0];
        end
        else if (p[1:0] == 2'd0)
        begin
            first_sum_odd = 1'b0;
        end

        recent_samples[3] = recent_samples[2];
        recent_samples[2] = recent_samples[1];
        recent_samples[1] = recent_samples[0];
        recent_samples[0] = raw;

        if (last)
        begin
            line_position = '0;
            first_sum_odd = 1'b0;
        end
        else
        begin
            line_position = 12'(p + 1);
        end

        res.coefficient = clip_coef(v);
        res.line_done = last;
    endtask

    // Compare accepted coefficients first, then apply register writes, then predict.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        band_coef_t want;
        band_coef_t fresh;
        bit         produced;
        if (!rst_n)
        begin
            band_is_high = 1'b0;
            quarter_width = QUARTER_WIDTH_RESET;
            for (int i = 0; i < 4; i++)
                recent_samples[i] = '0;
            line_position = '0;
            first_sum_odd = 1'b0;
            expected_coefs.delete();
            coefs_outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_coefs.size() == 0)
                begin
                    report_mismatch($sformatf("coefficient %0d with none expected",
                                              $signed(m_axis_tdata)));
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    if (m_axis_tdata !== want.coefficient)
                        report_mismatch($sformatf("coefficient %0d, expected %0d",
                                                  $signed(m_axis_tdata),
                                                  $signed(want.coefficient)));
                    if (m_axis_tlast !== want.line_done)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  m_axis_tlast, want.line_done));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_HIGH_PASS_MODE)
                    band_is_high = cfg_data[0];
                else if (cfg_index == CFG_IDX_QUARTER_WIDTH)
                    quarter_width = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                filter_sample(s_axis_tdata, produced, fresh);
                if (produced)
                    expected_coefs.push_back(fresh);
            end
            coefs_outstanding <= expected_coefs.size();
        end
    end

endmodule

### tb/tb_wavelet53_line_analysis.sv
// Testbench top for the 5/3 wavelet line analysis block: drives samples, register writes
// and output back-pressure; the checker module beside the block judges every coefficient.
// Depends on w53_pkg, wavelet53_line_analysis and wavelet53_line_analysis_checker.
module tb_wavelet53_line_analysis;
    import w53_pkg::*;

    localparam int RANDOM_ITEMS  = 1050;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT     = 3_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;     // [15:0] sample
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;          // [15:0] coefficient
    logic               m_axis_tlast;          // line_done
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_IDX_HIGH_PASS_MODE;
    logic [CFG_Q_W-1:0] cfg_data = '0;

    int mismatch_count;
    int coefs_outstanding;
    int send_idle_pct = 20;
    int recv_stall_pct = 84;

    // Three short lines of eight: low-pass extremes, high-pass saturation, odd pair sums.
    int directed_samples [24] = '{
        32767, -32768, 32767, -32768, -32768, 32767, 5, -7,
        -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
        1, 0, 2, 5, 1, -3, 4, 7
    };

    wavelet53_line_analysis DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    wavelet53_line_analysis_checker band_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .coefs_outstanding (coefs_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output back-pressure at the current stall rate.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Runaway guard.
    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly full-range values, with small values for rounding and odd sums and the extremes.
    function automatic logic [15:0] random_sample();
        int small_val;
        logic [15:0] word;
        case ($urandom_range(9))
            0: word = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1, 2, 3:
            begin
                small_val = int'($urandom_range(16)) - 8;
                word = small_val[15:0];
            end
            default: word = 16'($urandom());
        endcase
        return word;
    endfunction

    // Short lines most of the time, the out-of-range and largest widths now and then.
    function automatic logic [CFG_Q_W-1:0] random_quarter_width();
        logic [CFG_Q_W-1:0] q;
        case ($urandom_range(19))
            0: q = 11'd0;
            1: q = 11'd1;
            2: q = 11'd1024;
            3: q = 11'd2047;
            4, 5, 6: q = CFG_Q_W'($urandom_range(40, 9));
            default: q = CFG_Q_W'($urandom_range(8, 2));
        endcase
        return q;
    endfunction

    task automatic write_register(input logic index, input logic [CFG_Q_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One sample request, after a random gap at the current idle rate.
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Hold the input until every coefficient has come and the pipeline has emptied.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (coefs_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          sent;
        int          phase_len;
        logic [15:0] word;
        sent = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines with the shortest width.
        write_register(CFG_IDX_HIGH_PASS_MODE, 11'd0);
        write_register(CFG_IDX_QUARTER_WIDTH, QUARTER_WIDTH_MIN);
        for (int i = 0; i < 8; i++)
        begin
            word = directed_samples[i][15:0];
            send_sample(word);
        end
        drain_pipeline();
        write_register(CFG_IDX_HIGH_PASS_MODE, 11'd1);
        for (int i = 8; i < 24; i++)
        begin
            word = directed_samples[i][15:0];
            send_sample(word);
        end
        drain_pipeline();

        // Random phases; their lengths do not follow line ends, so width and band
        // changes also land in the middle of a line.
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 20;
                recv_stall_pct = 84;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 84;
                recv_stall_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_register(CFG_IDX_HIGH_PASS_MODE, CFG_Q_W'($urandom_range(1)));
            write_register(CFG_IDX_QUARTER_WIDTH, random_quarter_width());
            phase_len = $urandom_range(90, 10);
            for (int i = 0; i < phase_len; i++)
            begin
                send_sample(random_sample());
                sent++;
            end
            drain_pipeline();
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
